>>> hw/rtl/rfa_pkg.sv
// Shared types, constants and helper functions for the RFID ASCII frame checker.
// Used by the front, the frame command queue, the back and the top level.
package rfa_pkg;

  // Number of ASCII hex characters in one tag ID.
  localparam int unsigned ID_CHARS = 10;
  localparam int unsigned IDX_W    = $clog2(ID_CHARS);

  // Depth of the frame command queue between front and back.
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CHAR_INDEX_W = 4;
  localparam int unsigned POS_W        = 5;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'd2;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'd3;

  // Frame positions: hunting, ID characters, two checksum characters,
  // two skipped bytes (CR, LF) and the end byte.
  localparam logic [POS_W-1:0] POS_HUNT     = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ID_FIRST = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ID_LAST  = POS_W'(ID_CHARS);
  localparam logic [POS_W-1:0] POS_CHK0     = POS_W'(ID_CHARS + 1);
  localparam logic [POS_W-1:0] POS_CHK1     = POS_W'(ID_CHARS + 2);
  localparam logic [POS_W-1:0] POS_SKIP0    = POS_W'(ID_CHARS + 3);
  localparam logic [POS_W-1:0] POS_SKIP1    = POS_W'(ID_CHARS + 4);
  localparam logic [POS_W-1:0] POS_END      = POS_W'(ID_CHARS + 5);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_END   = 2'd1,
    ST_BAD_CHECK = 2'd2
  } status_e;

  // One finished frame handed from the front to the back.
  typedef struct packed {
    status_e                             status;
    logic [ID_CHARS-1:0][BYTE_W-1:0]     id;
  } frame_cmd_t;

  // ASCII hex digit to value, with 8-bit wrap for anything not a decimal digit.
  function automatic logic [BYTE_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
    if (c > 8'd47 && c < 8'd58) begin
      return c - 8'd48;
    end
    return c - 8'd55;
  endfunction

  // Value back to ASCII; values that are below 10 as a signed byte take the digit offset.
  function automatic logic [BYTE_W-1:0] hex_encode(input logic [BYTE_W-1:0] v);
    if (v < 8'd10 || v[BYTE_W-1]) begin
      return v + 8'd48;
    end
    return v + 8'd55;
  endfunction

endpackage

>>> hw/rtl/rfa_front.sv
// Front of the frame checker: tracks the frame position, stores the ID characters,
// folds the checksum as bytes arrive and queues one command per finished frame.
// Depends on rfa_pkg.
module rfa_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [rfa_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                     cmd_full_i,
  output logic                     cmd_push_o,
  output rfa_pkg::frame_cmd_t      cmd_o
);

  logic [rfa_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [rfa_pkg::BYTE_W-1:0] even_x_q, even_x_d;
  logic [rfa_pkg::BYTE_W-1:0] odd_x_q, odd_x_d;
  logic [rfa_pkg::BYTE_W-1:0] chk0_q, chk1_q;
  logic [rfa_pkg::ID_CHARS-1:0][rfa_pkg::BYTE_W-1:0] id_store_q;

  logic                       at_end;
  logic                       accept;
  logic                       id_wr;
  logic [rfa_pkg::IDX_W-1:0]  id_wr_idx;
  logic [rfa_pkg::POS_W-1:0]  pos_minus_one;
  logic [rfa_pkg::BYTE_W-1:0] rx_value;
  logic                       check_ok;

  // Only the end byte needs room in the command queue.
  assign at_end = (pos_q == rfa_pkg::POS_END);
  assign full   = at_end && cmd_full_i;
  assign accept = push && !full;

  assign pos_minus_one = pos_q - rfa_pkg::POS_W'(1);
  assign id_wr_idx     = pos_minus_one[rfa_pkg::IDX_W-1:0];
  assign rx_value      = rfa_pkg::hex_value(rx_byte_i);
  assign id_wr         = accept &&
                         (pos_q inside {[rfa_pkg::POS_ID_FIRST:rfa_pkg::POS_ID_LAST]});

  assign check_ok = (rfa_pkg::hex_encode(even_x_q) == chk0_q) &&
                    (rfa_pkg::hex_encode(odd_x_q) == chk1_q);

  always_comb begin
    pos_d      = pos_q;
    even_x_d   = even_x_q;
    odd_x_d    = odd_x_q;
    cmd_push_o = 1'b0;
    cmd_o.id   = id_store_q;
    if (rx_byte_i != rfa_pkg::END_BYTE) begin
      cmd_o.status = rfa_pkg::ST_BAD_END;
    end else if (!check_ok) begin
      cmd_o.status = rfa_pkg::ST_BAD_CHECK;
    end else begin
      cmd_o.status = rfa_pkg::ST_OK;
    end

    if (accept) begin
      if (pos_q == rfa_pkg::POS_HUNT) begin
        if (rx_byte_i == rfa_pkg::START_BYTE) begin
          pos_d    = rfa_pkg::POS_ID_FIRST;
          even_x_d = '0;
          odd_x_d  = '0;
        end
      end else if (at_end) begin
        pos_d      = rfa_pkg::POS_HUNT;
        cmd_push_o = 1'b1;
      end else begin
        pos_d = pos_q + rfa_pkg::POS_W'(1);
        if (id_wr) begin
          // Odd frame positions hold the even-indexed ID characters.
          if (pos_q[0]) begin
            even_x_d = even_x_q ^ rx_value;
          end else begin
            odd_x_d = odd_x_q ^ rx_value;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= rfa_pkg::POS_HUNT;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    even_x_q <= even_x_d;
    odd_x_q  <= odd_x_d;
    if (id_wr) begin
      id_store_q[id_wr_idx] <= rx_byte_i;
    end
    if (accept && pos_q == rfa_pkg::POS_CHK0) begin
      chk0_q <= rx_byte_i;
    end
    if (accept && pos_q == rfa_pkg::POS_CHK1) begin
      chk1_q <= rx_byte_i;
    end
  end

  a_end_returns_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && at_end) |=> (pos_q == rfa_pkg::POS_HUNT))
    else $error("frame position did not return to hunting after the end byte");

endmodule

>>> hw/rtl/rfa_cmd_fifo.sv
// Short queue of finished frame commands between the front and the back.
// Depends on rfa_pkg for the command type and the queue depth.
module rfa_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rfa_pkg::frame_cmd_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output rfa_pkg::frame_cmd_t pop_data_o
);

  rfa_pkg::frame_cmd_t                 entry_q [rfa_pkg::CMD_DEPTH];
  logic [rfa_pkg::CMD_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [rfa_pkg::CMD_CNT_W-1:0]       count_q;
  logic                                do_push, do_pop;

  localparam logic [rfa_pkg::CMD_PTR_W-1:0] PtrLast = rfa_pkg::CMD_PTR_W'(rfa_pkg::CMD_DEPTH - 1);
  localparam logic [rfa_pkg::CMD_CNT_W-1:0] CntFull = rfa_pkg::CMD_CNT_W'(rfa_pkg::CMD_DEPTH);

  assign full_o     = (count_q == CntFull);
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + rfa_pkg::CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + rfa_pkg::CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + rfa_pkg::CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - rfa_pkg::CMD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("frame command pushed into a full queue");

endmodule

>>> hw/rtl/rfa_back.sv
// Back of the frame checker: takes one frame command at a time and plays it out
// as result words through an output register. Depends on rfa_pkg.
module rfa_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  input  rfa_pkg::frame_cmd_t                cmd_i,
  output logic                               cmd_pop_o,
  output logic                               empty,
  input  logic                               pop,
  output logic [rfa_pkg::BYTE_W-1:0]         id_char_o,
  output logic [rfa_pkg::CHAR_INDEX_W-1:0]   char_index_o,
  output logic [1:0]                         status_o,
  output logic                               last_o
);

  localparam logic [rfa_pkg::IDX_W-1:0] IdxLast = rfa_pkg::IDX_W'(rfa_pkg::ID_CHARS - 1);

  logic                       busy_q, busy_d;
  logic [rfa_pkg::IDX_W-1:0]  idx_q, idx_d;
  rfa_pkg::frame_cmd_t        cmd_q, cmd_d;
  logic                       out_valid_q, out_valid_d;
  logic [rfa_pkg::BYTE_W-1:0]       out_char_q, out_char_d;
  logic [rfa_pkg::CHAR_INDEX_W-1:0] out_idx_q, out_idx_d;
  rfa_pkg::status_e           out_status_q, out_status_d;
  logic                       out_last_q, out_last_d;

  logic                       out_free;
  logic                       issue;
  logic                       is_last;

  assign out_free  = !out_valid_q || pop;
  assign issue     = busy_q && out_free;
  assign is_last   = (cmd_q.status != rfa_pkg::ST_OK) || (idx_q == IdxLast);
  assign cmd_pop_o = !busy_q && cmd_valid_i;

  always_comb begin
    busy_d       = busy_q;
    idx_d        = idx_q;
    cmd_d        = cmd_q;
    out_valid_d  = out_valid_q;
    out_char_d   = out_char_q;
    out_idx_d    = out_idx_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    if (cmd_pop_o) begin
      busy_d = 1'b1;
      cmd_d  = cmd_i;
      idx_d  = '0;
    end

    if (issue) begin
      out_valid_d  = 1'b1;
      out_status_d = cmd_q.status;
      out_last_d   = is_last;
      if (cmd_q.status == rfa_pkg::ST_OK) begin
        out_char_d = cmd_q.id[idx_q];
        out_idx_d  = rfa_pkg::CHAR_INDEX_W'(idx_q);
      end else begin
        out_char_d = '0;
        out_idx_d  = '0;
      end
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + rfa_pkg::IDX_W'(1);
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    out_char_q   <= out_char_d;
    out_idx_q    <= out_idx_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign empty        = !out_valid_q;
  assign id_char_o    = out_char_q;
  assign char_index_o = out_idx_q;
  assign status_o     = out_status_q;
  assign last_o       = out_last_q;

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && is_last) |=> !busy_q)
    else $error("back stayed busy after issuing the last word of a run");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= IdxLast))
    else $error("character index ran past the ID length");

  a_error_word_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && cmd_q.status != rfa_pkg::ST_OK) |=> (out_valid_q && out_last_q))
    else $error("error word was not flagged as last");

endmodule

>>> hw/rtl/rfid_ascii_frame_checker_core.sv
// Top level of the RFID ASCII frame checker: front, frame command queue and back.
// Depends on rfa_pkg, rfa_front, rfa_cmd_fifo and rfa_back.
//
//   channel   direction  handshake          words
//   rx        in         push / full        rx_byte_i
//   result    out        empty / pop        id_char_o, char_index_o, status_o, last_o
//
// One received byte is taken per cycle; full rises only on the end byte of a frame
// while the two-entry command queue holds two frames not yet started by the back.
// A good frame plays out as ID_CHARS result words, one per cycle while the output
// register is free (empty or popped); a bad frame gives one word. The back takes
// a new command in the cycle after the last word of the previous one is issued.
// Reset clears the frame position, the queue pointers and the output valid flag;
// the ID and checksum stores need no clearing. A stalled pop holds the output word.
module rfid_ascii_frame_checker_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [rfa_pkg::BYTE_W-1:0]       rx_byte_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [rfa_pkg::BYTE_W-1:0]       id_char_o,
  output logic [rfa_pkg::CHAR_INDEX_W-1:0] char_index_o,
  output logic [1:0]                       status_o,
  output logic                             last_o
);

  rfa_pkg::frame_cmd_t front_cmd;
  rfa_pkg::frame_cmd_t back_cmd;
  logic                cmd_push;
  logic                cmd_full;
  logic                cmd_valid;
  logic                cmd_pop;

  rfa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .rx_byte_i  (rx_byte_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd)
  );

  rfa_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (front_cmd),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .valid_o     (cmd_valid),
    .pop_data_o  (back_cmd)
  );

  rfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (back_cmd),
    .cmd_pop_o    (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .id_char_o    (id_char_o),
    .char_index_o (char_index_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule
